@@ rtl/tmsl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmsl_pkg: shared types and constants of the trimmed-mean slew filter
// Field widths, register indexes, reset values and the reciprocal constants
// used for the divisions by three and by ten.
// ----------------------------------------------------------------------------
package tmsl_pkg;

  localparam int CH_W     = 2;
  localparam int SAMPLE_W = 12;
  localparam int TRIM_W   = 14;   // sum of the middle three samples
  localparam int QUOT_W   = 9;    // level / 10, at most 409

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CH_W-1:0]     chan_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_RISE_STEP = 2'd0;
  localparam logic [1:0] REG_FALL_STEP = 2'd1;

  localparam sample_t RISE_STEP_RESET = 12'd50;
  localparam sample_t FALL_STEP_RESET = 12'd60;

  // x / 3 = (x * 43691) >> 17, exact for x below 2^16.
  localparam logic [15:0] DIV3_MUL   = 16'd43691;
  localparam int          DIV3_SHIFT = 17;
  // x / 10 = (x * 52429) >> 19, exact for x below 2^16.
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam int QDEPTH = 2;

  typedef struct packed {
    chan_t   channel;
    sample_t level;
  } level_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    sample_t rise_step;
    sample_t fall_step;
  } slew_cfg_t;

endpackage

`default_nettype wire

@@ rtl/trimmed_mean_slew_limit_filter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trimmed_mean_slew_limit_filter_unit: trimmed mean filter with slew limiter
// Drops the smallest and largest of five samples, averages the rest,
// truncates to a multiple of ten and slew-limits a per-channel smoothed value.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   channel, sample_a .. sample_e
//   out      out_valid / out_ready out_channel, level, smoothed_level
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One beat in and one beat out per cycle when the output is not stalled.
// Each beat passes three front stages (trim and sum, divide by three,
// divide by ten), one queue slot and the output register of the slew stage.
// Reset clears the smoothed values to zero and the limits to 50 and 60.
// A stalled output fills the two-entry queue, then the front holds in_ready low.
// ----------------------------------------------------------------------------
module trimmed_mean_slew_limit_filter_unit #(
  parameter int CHANNELS = 4
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire tmsl_pkg::chan_t   channel,
  input  wire tmsl_pkg::sample_t sample_a,
  input  wire tmsl_pkg::sample_t sample_b,
  input  wire tmsl_pkg::sample_t sample_c,
  input  wire tmsl_pkg::sample_t sample_d,
  input  wire tmsl_pkg::sample_t sample_e,
  output logic                   out_valid,
  input  wire                    out_ready,
  output tmsl_pkg::chan_t        out_channel,
  output tmsl_pkg::sample_t      level,
  output tmsl_pkg::sample_t      smoothed_level,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [1:0]              cfg_index,
  input  wire tmsl_pkg::sample_t cfg_data
);
  import tmsl_pkg::*;

  slew_cfg_t      cfg;
  logic           push;
  level_item_t    push_item;
  logic           pop;
  level_item_t    head;
  queue_status_t  q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_step <= RISE_STEP_RESET;
      cfg.fall_step <= FALL_STEP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RISE_STEP: cfg.rise_step <= cfg_data;
        REG_FALL_STEP: cfg.fall_step <= cfg_data;
        default: ;
      endcase
    end
  end

  tmsl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .channel    (channel),
    .sample_a   (sample_a),
    .sample_b   (sample_b),
    .sample_c   (sample_c),
    .sample_d   (sample_d),
    .sample_e   (sample_e),
    .queue_full (q_status.full),
    .push       (push),
    .push_item  (push_item)
  );

  tmsl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  tmsl_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head           (head),
    .head_valid     (!q_status.empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .level          (level),
    .smoothed_level (smoothed_level)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  a_back_drains: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !q_status.empty) |=> out_valid)
    else $error("queued item not moved to an empty output register");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level <= 12'd4090))
    else $error("level out of range");

  a_unknown_channel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ({3'b000, out_channel} >= 5'(CHANNELS))) |-> (smoothed_level == '0))
    else $error("smoothed level nonzero for a channel without storage");

endmodule

`default_nettype wire

@@ rtl/tmsl_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmsl_front: trimmed mean and level quantizer
// Three stages: drop min and max and sum the rest, divide by three, divide
// by ten. The level (quotient times ten) is handed to the queue.
// ----------------------------------------------------------------------------
module tmsl_front (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire tmsl_pkg::chan_t   channel,
  input  wire tmsl_pkg::sample_t sample_a,
  input  wire tmsl_pkg::sample_t sample_b,
  input  wire tmsl_pkg::sample_t sample_c,
  input  wire tmsl_pkg::sample_t sample_d,
  input  wire tmsl_pkg::sample_t sample_e,
  input  wire                    queue_full,
  output logic                   push,
  output tmsl_pkg::level_item_t  push_item
);
  import tmsl_pkg::*;

  logic                    advance;
  sample_t                 smp [5];
  sample_t                 lo;
  sample_t                 hi;
  logic [TRIM_W:0]         total;
  logic [TRIM_W-1:0]       trim;
  logic [TRIM_W+15:0]      prod3;
  logic [SAMPLE_W+15:0]    prod10;

  logic                    s1_valid;
  logic                    s2_valid;
  logic                    s3_valid;
  chan_t                   s1_channel;
  chan_t                   s2_channel;
  chan_t                   s3_channel;
  logic [TRIM_W-1:0]       s1_trim;
  sample_t                 s2_mean;
  logic [QUOT_W-1:0]       s3_quot;

  // The whole pipeline moves together whenever its last stage can drain.
  assign advance  = !s3_valid || !queue_full;
  assign in_ready = advance;
  assign push     = s3_valid && !queue_full;

  assign smp[0] = sample_a;
  assign smp[1] = sample_b;
  assign smp[2] = sample_c;
  assign smp[3] = sample_d;
  assign smp[4] = sample_e;

  always_comb begin
    lo    = smp[0];
    hi    = smp[0];
    total = '0;
    for (int i = 0; i < 5; i++) begin
      if (smp[i] < lo) begin
        lo = smp[i];
      end
      if (smp[i] > hi) begin
        hi = smp[i];
      end
      total = total + (TRIM_W+1)'(smp[i]);
    end
    // Ties do no harm: one minimum and one maximum come off the total.
    trim = TRIM_W'(total - (TRIM_W+1)'(lo) - (TRIM_W+1)'(hi));
  end

  assign prod3  = (TRIM_W+16)'(s1_trim) * (TRIM_W+16)'(DIV3_MUL);
  assign prod10 = (SAMPLE_W+16)'(s2_mean) * (SAMPLE_W+16)'(DIV10_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_channel <= channel;
      s1_trim    <= trim;
      s2_channel <= s1_channel;
      s2_mean    <= prod3[DIV3_SHIFT +: SAMPLE_W];
      s3_channel <= s2_channel;
      s3_quot    <= prod10[DIV10_SHIFT +: QUOT_W];
    end
  end

  // Times ten as shift and add.
  assign push_item.channel = s3_channel;
  assign push_item.level   = SAMPLE_W'({s3_quot, 3'b000}) + SAMPLE_W'({s3_quot, 1'b0});

endmodule

`default_nettype wire

@@ rtl/tmsl_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmsl_queue: short FIFO between the front and the back
// Two entries; full and empty are decoded from the registered count.
// ----------------------------------------------------------------------------
module tmsl_queue (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  input  wire tmsl_pkg::level_item_t   push_item,
  input  wire                          pop,
  output tmsl_pkg::level_item_t        head,
  output tmsl_pkg::queue_status_t      status
);
  import tmsl_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  level_item_t        entries [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign status.full  = (count == CNT_W'(QDEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tmsl_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmsl_back: per-channel slew limiter and output register
// Reads the channel's smoothed value, limits the move toward the new level,
// writes it back and registers the result beat in the same cycle.
// ----------------------------------------------------------------------------
module tmsl_back #(
  parameter int CHANNELS = 4
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire tmsl_pkg::slew_cfg_t     cfg,
  input  wire tmsl_pkg::level_item_t   head,
  input  wire                          head_valid,
  output logic                         pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output tmsl_pkg::chan_t              out_channel,
  output tmsl_pkg::sample_t            level,
  output tmsl_pkg::sample_t            smoothed_level
);
  import tmsl_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  sample_t            store [CHANNELS];
  logic [IDX_W-1:0]   idx;
  logic               in_range;
  sample_t            old_v;
  sample_t            new_v;
  sample_t            slewed;

  assign idx      = IDX_W'(head.channel);
  assign in_range = ({3'b000, head.channel} < 5'(CHANNELS));
  assign old_v    = in_range ? store[idx] : '0;
  assign new_v    = head.level;
  assign pop      = head_valid && (!out_valid || out_ready);

  // The result always lies between old and new, so it stays in range.
  always_comb begin
    if (new_v >= old_v) begin
      slewed = ((new_v - old_v) > cfg.rise_step) ? old_v + cfg.rise_step : new_v;
    end else begin
      slewed = ((old_v - new_v) > cfg.fall_step) ? old_v - cfg.fall_step : new_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        store[i] <= '0;
      end
    end else if (pop && in_range) begin
      store[idx] <= slewed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_channel    <= head.channel;
      level          <= new_v;
      smoothed_level <= in_range ? slewed : '0;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the trimmed-mean slew-limit filter
// Drives groups of five samples per channel over a valid/ready port, predicts
// the trimmed level and the slew-limited smoothed value of each channel, and
// compares every output beat in order. Step limits are rewritten between
// phases while the pipeline is empty; sender gaps and receiver stalls vary.
// ----------------------------------------------------------------------------
module tb_top;
  import tmsl_pkg::*;

  localparam int CHANNEL_COUNT = 4;
  localparam int PIPE_LATENCY  = 5;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  // Indexes outside the register map; writes to them must be ignored.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    chan_t   channel;
    sample_t level;
    sample_t smoothed;
  } level_result_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  chan_t       channel   = '0;
  sample_t     sample_a  = '0;
  sample_t     sample_b  = '0;
  sample_t     sample_c  = '0;
  sample_t     sample_d  = '0;
  sample_t     sample_e  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  chan_t       out_channel;
  sample_t     level;
  sample_t     smoothed_level;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  sample_t     cfg_data  = '0;

  // Predictor state.
  int unsigned rise_limit = RISE_STEP_RESET;
  int unsigned fall_limit = FALL_STEP_RESET;
  int unsigned smooth_by_channel [CHANNEL_COUNT];

  level_result_t pending_results[$];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int groups_sent    = 0;
  int results_seen   = 0;
  int reg_writes     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  trimmed_mean_slew_limit_filter_unit #(
    .CHANNELS(CHANNEL_COUNT)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .channel        (channel),
    .sample_a       (sample_a),
    .sample_b       (sample_b),
    .sample_c       (sample_c),
    .sample_d       (sample_d),
    .sample_e       (sample_e),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .level          (level),
    .smoothed_level (smoothed_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic level_result_t predict_level(input chan_t ch, input sample_t a,
                                                  input sample_t b, input sample_t c,
                                                  input sample_t d, input sample_t e);
    level_result_t res;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   total;
    int unsigned   lvl;
    int unsigned   prev;
    int unsigned   nxt;
    lo = a;
    hi = a;
    if (b < lo) lo = b;
    if (c < lo) lo = c;
    if (d < lo) lo = d;
    if (e < lo) lo = e;
    if (b > hi) hi = b;
    if (c > hi) hi = c;
    if (d > hi) hi = d;
    if (e > hi) hi = e;
    total = a + b + c + d + e;
    lvl = (((total - lo - hi) / 3) / 10) * 10;
    nxt = 0;
    if (ch < CHANNEL_COUNT) begin
      prev = smooth_by_channel[ch];
      if (lvl >= prev) begin
        nxt = (lvl - prev > rise_limit) ? prev + rise_limit : lvl;
      end else begin
        nxt = (prev - lvl > fall_limit) ? prev - fall_limit : lvl;
      end
      nxt = nxt & 12'hFFF;
      smooth_by_channel[ch] = nxt;
    end
    res.channel  = ch;
    res.level    = sample_t'(lvl);
    res.smoothed = sample_t'(nxt);
    return res;
  endfunction

  // Output monitor: every accepted beat is matched against the oldest prediction.
  always @(posedge clk) begin
    level_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("[%0t] unexpected beat: ch %0d level %0d smoothed %0d",
                   $time, out_channel, level, smoothed_level);
        mismatch_count <= mismatch_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (out_channel !== want.channel || level !== want.level ||
            smoothed_level !== want.smoothed) begin
          if (mismatch_count < REPORT_MAX)
            $display("[%0t] mismatch: exp ch %0d level %0d smoothed %0d, got ch %0d level %0d smoothed %0d",
                     $time, want.channel, want.level, want.smoothed,
                     out_channel, level, smoothed_level);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  // Sends one beat and leaves valid high unless the sender decides to idle.
  task automatic send_group(input chan_t ch, input sample_t a, input sample_t b,
                            input sample_t c, input sample_t d, input sample_t e);
    in_valid <= 1'b1;
    channel  <= ch;
    sample_a <= a;
    sample_b <= b;
    sample_c <= c;
    sample_d <= d;
    sample_e <= e;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_level(ch, a, b, c, d, e));
    groups_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
  task automatic write_reg(input logic [1:0] idx, input sample_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RISE_STEP: rise_limit = data;
      REG_FALL_STEP: fall_limit = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_limits(input sample_t rise, input sample_t fall);
    write_reg(REG_RISE_STEP, rise);
    write_reg(REG_FALL_STEP, fall);
    cfg_valid <= 1'b0;
  endtask

  function automatic sample_t pick_limit();
    case ($urandom_range(3))
      0: return sample_t'($urandom_range(20));
      1: return sample_t'($urandom_range(300));
      2: return sample_t'($urandom);
      default: return $urandom_range(1) ? 12'hFFF : 12'h000;
    endcase
  endfunction

  function automatic sample_t clamp_sample(input int v);
    if (v < 0) return 12'h000;
    if (v > 4095) return 12'hFFF;
    return sample_t'(v);
  endfunction

  function automatic sample_t extreme_sample();
    case ($urandom_range(3))
      0: return 12'h000;
      1: return 12'hFFF;
      2: return sample_t'($urandom_range(15));
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_random_group();
    chan_t   ch;
    sample_t s0, s1, s2, s3, s4;
    int      center;
    int      spread;
    ch = chan_t'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // Level near the current smoothed value, so both limited and
        // unlimited steps occur.
        center = int'(smooth_by_channel[ch]) + int'($urandom_range(600)) - 300;
        spread = $urandom_range(12);
        s0 = clamp_sample(center + int'($urandom_range(2 * spread)) - spread);
        s1 = clamp_sample(center + int'($urandom_range(2 * spread)) - spread);
        s2 = clamp_sample(center + int'($urandom_range(2 * spread)) - spread);
        s3 = clamp_sample(center + int'($urandom_range(2 * spread)) - spread);
        s4 = clamp_sample(center + int'($urandom_range(2 * spread)) - spread);
      end
      4, 5, 6: begin
        s0 = sample_t'($urandom);
        s1 = sample_t'($urandom);
        s2 = sample_t'($urandom);
        s3 = sample_t'($urandom);
        s4 = sample_t'($urandom);
      end
      7: begin
        s0 = extreme_sample();
        s1 = extreme_sample();
        s2 = extreme_sample();
        s3 = extreme_sample();
        s4 = extreme_sample();
      end
      default: begin
        // Heavy ties: at most two distinct values.
        s0 = sample_t'($urandom);
        s1 = $urandom_range(1) ? s0 : sample_t'($urandom);
        s2 = $urandom_range(1) ? s0 : s1;
        s3 = $urandom_range(1) ? s1 : s0;
        s4 = $urandom_range(1) ? s0 : s1;
      end
    endcase
    send_group(ch, s0, s1, s2, s3, s4);
  endtask

  task automatic test_trim_extremes();
    // Runs at the reset limits of 50 up and 60 down.
    send_group(2'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_group(2'd1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_group(2'd1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_group(2'd2, 12'hFFF, 12'd0, 12'd0, 12'd0, 12'd0);
    send_group(2'd2, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_group(2'd3, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5);
    send_group(2'd3, 12'd100, 12'd100, 12'd100, 12'd100, 12'd100);
    send_group(2'd0, 12'd29, 12'd30, 12'd31, 12'd30, 12'd30);
    send_group(2'd0, 12'd0, 12'd500, 12'd600, 12'd700, 12'hFFF);
    send_group(2'd0, 12'd500, 12'hFFF, 12'd0, 12'd600, 12'd700);
    send_group(2'd0, 12'd600, 12'd700, 12'hFFF, 12'd500, 12'd0);
    send_group(2'd0, 12'hFFF, 12'd0, 12'd700, 12'd0, 12'hFFF);
    send_group(2'd3, 12'd39, 12'd40, 12'd41, 12'd0, 12'd4000);
    send_group(2'd1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    drain_pipe();
  endtask

  task automatic test_limit_extremes();
    set_limits(12'hFFF, 12'hFFF);
    send_group(2'd2, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_group(2'd2, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_group(2'd2, 12'd2000, 12'd2001, 12'd2002, 12'd1999, 12'd2050);
    drain_pipe();
    // Zero limits freeze the smoothed value in both directions.
    set_limits(12'd0, 12'd0);
    send_group(2'd2, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_group(2'd2, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    drain_pipe();
    set_limits(12'd1, 12'hFFF);
    send_group(2'd1, 12'd3000, 12'd3000, 12'd3000, 12'd3000, 12'd3000);
    send_group(2'd1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    drain_pipe();
  endtask

  task automatic test_unknown_index();
    set_limits(12'd7, 12'd9);
    drain_pipe();
    write_reg(REG_SPARE_A, 12'hFFF);
    write_reg(REG_SPARE_B, 12'h000);
    write_reg(REG_SPARE_A, 12'h000);
    write_reg(REG_SPARE_B, 12'hFFF);
    cfg_valid <= 1'b0;
    send_group(2'd0, 12'd3000, 12'd3000, 12'd3000, 12'd3000, 12'd3000);
    send_group(2'd3, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    drain_pipe();
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall, input int count);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    set_limits(pick_limit(), pick_limit());
    for (int i = 0; i < count / 2; i++) send_random_group();
    // The sender holds off here until every outstanding beat has come back.
    drain_pipe();
    set_limits(pick_limit(), pick_limit());
    for (int i = count / 2; i < count; i++) send_random_group();
    drain_pipe();
  endtask

  task automatic test_random_no_idle();
    run_random_phase(0, 0, 120);
  endtask

  task automatic test_random_sender_idle();
    run_random_phase(82, 0, 120);
  endtask

  task automatic test_random_receiver_stall();
    run_random_phase(0, 82, 120);
  endtask

  task automatic test_random_both_idle();
    run_random_phase(17, 17, 120);
  endtask

  initial begin
    for (int i = 0; i < CHANNEL_COUNT; i++) smooth_by_channel[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_trim_extremes();
    test_limit_extremes();
    test_unknown_index();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    drain_pipe();
    $display("Sent %0d sample groups over %0d channels, compared %0d beats, %0d register writes.",
             groups_sent, CHANNEL_COUNT, results_seen, reg_writes);
    $display("Ran with no idling, 82%% sender gaps, 82%% output stalls and 17%% on both sides.");
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tmsl_pkg.sv
rtl/tmsl_front.sv
rtl/tmsl_queue.sv
rtl/tmsl_back.sv
rtl/trimmed_mean_slew_limit_filter_unit.sv
sim/tb_top.sv
